@@ hw/rtl/cbz_pkg.sv @@
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared types and constants of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  // Number of Bernstein terms of a cubic curve.
  localparam int TERMS = 4;

  // Number of control point registers and the width of the register index.
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_BITS = 4;

  // Register index map of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_P0_X = 4'd0,
    REG_P0_Y = 4'd1,
    REG_P1_X = 4'd2,
    REG_P1_Y = 4'd3,
    REG_P2_X = 4'd4,
    REG_P2_Y = 4'd5,
    REG_P3_X = 4'd6,
    REG_P3_Y = 4'd7
  } cfg_reg_e;

  // Valid and ready of one internal pipeline link.
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

@@ hw/rtl/cbz_weight.sv @@
// ----------------------------------------------------------------------------
// cbz_weight
// Three-stage pipeline that turns t into the Bernstein products
// u^3, t*u^2, t^2*u and t^3, where u = 1 - t.
// ----------------------------------------------------------------------------
module cbz_weight import cbz_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [FRAC_BITS:0]                param_t_i,
  output link_t                             out_link_o,
  input  logic                              out_ready_i,
  output logic [TERMS-1:0][3*FRAC_BITS:0]   weight_o
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int SQW = 2 * TW;
  localparam int CBW = 3 * TW;
  localparam int WW  = 3 * FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic v_a_q, v_b_q, v_c_q;
  logic en_a, en_b, en_c;

  logic [TW-1:0]  t_a_q, u_a_q, t_sat;
  logic [TW-1:0]  t_b_q, u_b_q;
  logic [SQW-1:0] tt_b_q, uu_b_q, tu_b_q;
  logic [CBW-1:0] uuu, tuu, ttu, ttt;
  logic [TERMS-1:0][WW-1:0] weight_q;

  // A stage loads when it is empty or when its contents move on.
  assign en_c = !v_c_q || out_ready_i;
  assign en_b = !v_b_q || en_c;
  assign en_a = !v_a_q || en_b;
  assign in_ready_o = en_a;

  assign t_sat = (param_t_i > ONE) ? ONE : param_t_i;

  assign uuu = CBW'(uu_b_q) * CBW'(u_b_q);
  assign tuu = CBW'(tu_b_q) * CBW'(u_b_q);
  assign ttu = CBW'(tt_b_q) * CBW'(u_b_q);
  assign ttt = CBW'(tt_b_q) * CBW'(t_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else begin
      if (en_a) v_a_q <= in_valid_i;
      if (en_b) v_b_q <= v_a_q;
      if (en_c) v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      t_a_q <= t_sat;
      u_a_q <= ONE - t_sat;
    end
    if (en_b) begin
      t_b_q  <= t_a_q;
      u_b_q  <= u_a_q;
      tt_b_q <= SQW'(t_a_q) * SQW'(t_a_q);
      uu_b_q <= SQW'(u_a_q) * SQW'(u_a_q);
      tu_b_q <= SQW'(t_a_q) * SQW'(u_a_q);
    end
    if (en_c) begin
      weight_q[0] <= uuu[WW-1:0];
      weight_q[1] <= tuu[WW-1:0];
      weight_q[2] <= ttu[WW-1:0];
      weight_q[3] <= ttt[WW-1:0];
    end
  end

  assign out_link_o.valid = v_c_q;
  assign out_link_o.ready = en_c;
  assign weight_o = weight_q;

endmodule

@@ hw/rtl/cbz_blend.sv @@
// ----------------------------------------------------------------------------
// cbz_blend
// Three-stage pipeline that weights the control coordinates, sums the terms
// in a registered tree and keeps the integer part of each coordinate.
// ----------------------------------------------------------------------------
module cbz_blend import cbz_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [TERMS-1:0][3*FRAC_BITS:0]     weight_i,
  input  logic [TERMS-1:0][COORD_BITS+1:0]    coef_x_i,
  input  logic [TERMS-1:0][COORD_BITS+1:0]    coef_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [COORD_BITS-1:0]               pixel_x_o,
  output logic [COORD_BITS-1:0]               pixel_y_o
);

  localparam int WW    = 3 * FRAC_BITS + 1;
  localparam int CW    = COORD_BITS + 2;
  localparam int PW    = WW + CW;
  localparam int SHIFT = 3 * FRAC_BITS;

  logic v_d_q, v_e_q, v_f_q;
  logic en_d, en_e, en_f;

  logic [TERMS-1:0][PW-1:0]     prod_x_q, prod_y_q;
  logic [TERMS/2-1:0][PW:0]     pair_x_q, pair_y_q;
  logic [PW+1:0]                sum_x, sum_y;
  logic [COORD_BITS-1:0]        pixel_x_q, pixel_y_q;

  assign en_f = !v_f_q || out_ready_i;
  assign en_e = !v_e_q || en_f;
  assign en_d = !v_d_q || en_e;
  assign in_ready_o = en_d;

  assign sum_x = (PW+2)'(pair_x_q[0]) + (PW+2)'(pair_x_q[1]);
  assign sum_y = (PW+2)'(pair_y_q[0]) + (PW+2)'(pair_y_q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
      v_f_q <= 1'b0;
    end else begin
      if (en_d) v_d_q <= in_valid_i;
      if (en_e) v_e_q <= v_d_q;
      if (en_f) v_f_q <= v_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      for (int k = 0; k < TERMS; k++) begin
        prod_x_q[k] <= PW'(weight_i[k]) * PW'(coef_x_i[k]);
        prod_y_q[k] <= PW'(weight_i[k]) * PW'(coef_y_i[k]);
      end
    end
    if (en_e) begin
      for (int j = 0; j < TERMS/2; j++) begin
        pair_x_q[j] <= (PW+1)'(prod_x_q[2*j]) + (PW+1)'(prod_x_q[2*j+1]);
        pair_y_q[j] <= (PW+1)'(prod_y_q[2*j]) + (PW+1)'(prod_y_q[2*j+1]);
      end
    end
    if (en_f) begin
      // Dropping the fraction bits gives the floor of the exact sum.
      pixel_x_q <= sum_x[SHIFT +: COORD_BITS];
      pixel_y_q <= sum_y[SHIFT +: COORD_BITS];
    end
  end

  assign out_valid_o = v_f_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;

endmodule

@@ hw/rtl/cubic_bezier_point_eval.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Pipelined evaluation of a cubic Bezier curve at one parameter per word.
// ----------------------------------------------------------------------------
// Usage: load the four control points through the configuration channel
// (cfg_valid_i, cfg_index_i, cfg_data_i), one coordinate per write, index 0
// to 7 as p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y. Writes to other
// indexes are dropped. The channel is always ready. Points must be changed
// only while no word is in flight; the block itself does not enforce this.
// Each word on the slave stream carries t with FRAC_BITS fraction bits;
// a t above 1.0 is clamped to 1.0. Each master stream word returns the
// floor of the exact curve point as pixel_x and pixel_y.
// On the way from an accepted input word to tvalid on the output,
// three stages build the Bernstein products of t and 1 - t (the clamp and
// 1 - t, then the squares, then the cubes), and three more weight the
// control points, add the terms in a two-level tree and keep the integer
// bits. Throughput is one word per cycle while the receiver keeps up. When
// the receiver stalls, words pile up in the empty stages and s_axis_tready
// falls only once all six stages are full.
// Reset clears all control points to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval import cbz_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]               cfg_index_i,
  input  logic [COORD_BITS-1:0]                 cfg_data_i,
  // Slave stream: tdata = {zero fill, param_t}.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((FRAC_BITS+8)/8)*8-1:0]        s_axis_tdata,
  // Master stream: tdata = {zero fill, pixel_y, pixel_x}.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata
);

  localparam int WW  = 3 * FRAC_BITS + 1;
  localparam int CW  = COORD_BITS + 2;
  localparam int ODW = ((2*COORD_BITS+7)/8)*8;

  // Control point coordinates, index k is point k.
  logic [TERMS-1:0][COORD_BITS-1:0] p_x_q, p_y_q;
  logic [TERMS-1:0][CW-1:0]         coef_x, coef_y;

  link_t                    wgt_link;
  logic                     blend_ready;
  logic [TERMS-1:0][WW-1:0] weight;
  logic [COORD_BITS-1:0]    pixel_x, pixel_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_x_q <= '0;
      p_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_P0_X: p_x_q[0] <= cfg_data_i;
        REG_P0_Y: p_y_q[0] <= cfg_data_i;
        REG_P1_X: p_x_q[1] <= cfg_data_i;
        REG_P1_Y: p_y_q[1] <= cfg_data_i;
        REG_P2_X: p_x_q[2] <= cfg_data_i;
        REG_P2_Y: p_y_q[2] <= cfg_data_i;
        REG_P3_X: p_x_q[3] <= cfg_data_i;
        REG_P3_Y: p_y_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The binomial factor 3 of the inner terms is folded into the coordinates,
  // which the user must keep static while words are in flight (not enforced).
  always_comb begin
    for (int k = 0; k < TERMS; k++) begin
      if (k == 1 || k == 2) begin
        coef_x[k] = CW'(p_x_q[k]) + (CW'(p_x_q[k]) << 1);
        coef_y[k] = CW'(p_y_q[k]) + (CW'(p_y_q[k]) << 1);
      end else begin
        coef_x[k] = CW'(p_x_q[k]);
        coef_y[k] = CW'(p_y_q[k]);
      end
    end
  end

  cbz_weight #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .param_t_i   (s_axis_tdata[FRAC_BITS:0]),
    .out_link_o  (wgt_link),
    .out_ready_i (blend_ready),
    .weight_o    (weight)
  );

  cbz_blend #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wgt_link.valid),
    .in_ready_o  (blend_ready),
    .weight_i    (weight),
    .coef_x_i    (coef_x),
    .coef_y_i    (coef_y),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y)
  );

  assign m_axis_tdata = ODW'({pixel_y, pixel_x});

  // The Bernstein weights of any valid t add up to exactly 1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wgt_link.valid |->
      ((WW+2)'(weight[0]) + 3 * (WW+2)'(weight[1]) + 3 * (WW+2)'(weight[2])
       + (WW+2)'(weight[3])) == ((WW+2)'(1) << (3*FRAC_BITS)))
    else $error("Bernstein weights do not sum to one");

  // Input is refused only when the result register holds a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output");

  // Weights held back by the blend stage stay put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wgt_link.valid && !wgt_link.ready) |=> $stable(weight))
    else $error("stalled weights changed");

  // A stalled pipeline does not stall the weight stage while the
  // blend stage can still take a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_ready |-> wgt_link.ready)
    else $error("weight stage stalled with room downstream");

endmodule

@@ verif/tb_cubic_bezier_point_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_point_eval
// Self-checking testbench of the pipelined cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
// Each accepted parameter word is run through a bit-exact Bernstein predictor
// built from a shadow copy of the control points. The expected pixel is queued
// and every output word is checked against the oldest entry. Directed tests
// cover reset values, extreme curves, parameters at and above 1.0 and writes
// to unused register indexes. Random phases change the curve between runs
// while both streams idle at random. One test lets the receiver hold off long
// enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_point_eval;
  import cbz_pkg::*;

  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 16;
  localparam int S_W        = ((FRAC_BITS + 8) / 8) * 8;
  localparam int M_W        = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int T_BITS     = FRAC_BITS + 1;
  localparam int T_MAX      = (1 << T_BITS) - 1;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam logic [T_BITS-1:0] ONE = T_BITS'(1) << FRAC_BITS;

  // The pipeline is six stages deep; this covers it with margin.
  localparam int DRAIN_CYCLES = 10;
  // Long receiver hold-off, well beyond the pipeline depth.
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_WORDS   = 230;

  // One expected curve point, packed as on the master stream.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_y;
    logic [COORD_BITS-1:0] pixel_x;
  } pixel_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [COORD_BITS-1:0]   cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  // Fields from bit 0 up: param_t, zero fill.
  logic [S_W-1:0]          s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // Fields from bit 0 up: pixel_x, pixel_y, zero fill.
  logic [M_W-1:0]          m_axis_tdata;

  // Shadow of the control point registers, indexed by register index.
  logic [COORD_BITS-1:0] ctrl_point [NUM_REGS];
  pixel_t pixel_queue [$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  // Random idling of both streams is on while this is set.
  bit     idle_en = 1'b1;
  // Set by a test to make the receiver hold off for HOLD_CYCLES.
  bit     hold_req = 1'b0;

  cubic_bezier_point_eval #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // The run is ended here if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Exact Bernstein evaluation. The weights sum to 2^(3*FRAC_BITS), so the
  // weighted sum stays below 2^59 and fits a 64-bit accumulator; the shift
  // by 3*FRAC_BITS is the floor of the division.
  function automatic pixel_t bezier_point(input logic [T_BITS-1:0] param_t);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] weight [4];
    logic [63:0] sum_x;
    logic [63:0] sum_y;
    pixel_t      point;
    // A parameter above 1.0 is clamped, which lands on the end point.
    t = (param_t > ONE) ? 64'(ONE) : 64'(param_t);
    u = 64'(ONE) - t;
    weight[0] = u * u * u;
    weight[1] = 64'd3 * t * u * u;
    weight[2] = 64'd3 * t * t * u;
    weight[3] = t * t * t;
    sum_x = '0;
    sum_y = '0;
    for (int k = 0; k < TERMS; k++) begin
      sum_x += weight[k] * 64'(ctrl_point[2 * k]);
      sum_y += weight[k] * 64'(ctrl_point[2 * k + 1]);
    end
    point.pixel_x = COORD_BITS'(sum_x >> (3 * FRAC_BITS));
    point.pixel_y = COORD_BITS'(sum_y >> (3 * FRAC_BITS));
    return point;
  endfunction

  // Mostly legal parameters, with the ends of the range and clamped values
  // mixed in so that the top bit of param_t toggles often.
  function automatic logic [T_BITS-1:0] random_param();
    case ($urandom_range(15))
      0:       return '0;
      1:       return ONE;
      2, 3:    return T_BITS'($urandom_range(T_MAX, int'(ONE) + 1));
      default: return T_BITS'($urandom_range(int'(ONE), 0));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] random_coord();
    case ($urandom_range(7))
      0:       return '0;
      1:       return COORD_BITS'(COORD_MAX);
      default: return COORD_BITS'($urandom_range(COORD_MAX));
    endcase
  endfunction

  // Write one register. The channel valid stays high for a following write;
  // the caller lowers it once the sequence is done.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COORD_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < NUM_REGS) ctrl_point[idx[2:0]] = data;
  endtask

  task automatic set_curve(input logic [COORD_BITS-1:0] x0, y0, x1, y1,
                           input logic [COORD_BITS-1:0] x2, y2, x3, y3);
    write_reg(REG_P0_X, x0);
    write_reg(REG_P0_Y, y0);
    write_reg(REG_P1_X, x1);
    write_reg(REG_P1_Y, y1);
    write_reg(REG_P2_X, x2);
    write_reg(REG_P2_Y, y2);
    write_reg(REG_P3_X, x3);
    write_reg(REG_P3_Y, y3);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one parameter word, sometimes after a random gap if idling is on.
  // The expected point is queued on the edge that accepts the word.
  task automatic send_param(input logic [T_BITS-1:0] param_t);
    if (idle_en && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_W'(param_t);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixel_queue.push_back(bezier_point(param_t));
  endtask

  // Stop offering words and wait until every expected point has come back,
  // plus a few cycles so that nothing is left in flight.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(99) < 15) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Output checker: every accepted word is matched against the oldest
  // expected point, field by field.
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = pixel_t'(m_axis_tdata[2*COORD_BITS-1:0]);
      if (pixel_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, pixel_x %0d pixel_y %0d", $time,
                 got.pixel_x, got.pixel_y);
      end else begin
        want = pixel_queue.pop_front();
        if (got.pixel_x !== want.pixel_x) begin
          mismatch_count++;
          $display("%0t: pixel_x expected %0d actual %0d", $time,
                   want.pixel_x, got.pixel_x);
        end
        if (got.pixel_y !== want.pixel_y) begin
          mismatch_count++;
          $display("%0t: pixel_y expected %0d actual %0d", $time,
                   want.pixel_y, got.pixel_y);
        end
      end
    end
  end

  // With all points at their reset value of zero every sample is the origin.
  task automatic test_reset_points();
    send_param('0);
    send_param(ONE);
    wait_drain();
  endtask

  // Extreme curves, sampled at both ends, the middle, just below 1.0 and
  // at clamped values including the largest parameter word.
  task automatic test_extreme_curves();
    logic [T_BITS-1:0]     samples [7];
    logic [COORD_BITS-1:0] cmax;
    samples = '{'0, T_BITS'(1), ONE >> 1, ONE - 1, ONE, ONE + 1, T_BITS'(T_MAX)};
    cmax = COORD_BITS'(COORD_MAX);
    set_curve(cmax, cmax, cmax, cmax, cmax, cmax, cmax, cmax);
    foreach (samples[i]) send_param(samples[i]);
    wait_drain();
    // A zigzag that swings between the edges of the coordinate range.
    set_curve('0, cmax, cmax, '0, '0, cmax, cmax, '0);
    foreach (samples[i]) send_param(samples[i]);
    wait_drain();
  endtask

  // Writes to indexes past the last control point must leave the curve as is.
  task automatic test_unused_index();
    for (int idx = NUM_REGS; idx < (1 << CFG_IDX_BITS); idx++) begin
      write_reg(CFG_IDX_BITS'(idx), random_coord());
    end
    cfg_valid_i <= 1'b0;
    send_param('0);
    send_param(ONE >> 2);
    send_param(ONE);
    wait_drain();
  endtask

  task automatic test_random_curves();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                random_coord(), random_coord(), random_coord(), random_coord());
      repeat (PHASE_WORDS) send_param(random_param());
      wait_drain();
    end
  endtask

  // Back-to-back traffic on both streams.
  task automatic test_full_rate();
    idle_en = 1'b0;
    set_curve(random_coord(), random_coord(), random_coord(), random_coord(),
              random_coord(), random_coord(), random_coord(), random_coord());
    repeat (300) send_param(random_param());
    wait_drain();
    idle_en = 1'b1;
  endtask

  // The receiver holds off while words keep coming, so the pipeline fills
  // and the block has to stall its input until the hold-off ends.
  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (40) send_param(random_param());
    wait_drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_P0_X;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    foreach (ctrl_point[i]) ctrl_point[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_points();
    test_extreme_curves();
    test_unused_index();
    test_random_curves();
    test_full_rate();
    test_output_stall();

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ cubic_bezier_point_eval.f @@
hw/rtl/cbz_pkg.sv
hw/rtl/cbz_weight.sv
hw/rtl/cbz_blend.sv
hw/rtl/cubic_bezier_point_eval.sv
verif/tb_cubic_bezier_point_eval.sv
